/* rtl/murmur_hash_64a_macros.svh */
// assertion macros shared by the hash controller and datapath
// expects clk and arst_n in the scope of the module that uses them
`ifndef MURMUR_HASH_64A_MACROS_SVH
`define MURMUR_HASH_64A_MACROS_SVH

// same-cycle implication
`define MH_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hash check failed in %m");

// next-cycle implication
`define MH_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hash check failed in %m");

`endif

/* rtl/mh64a_pkg.sv */
// shared types, constants and helpers for the murmur 64a hash block
// no dependencies
package mh64a_pkg;

	localparam int unsigned WORD_W       = 64;
	localparam int unsigned COUNT_W      = 4;
	localparam int unsigned MSG_LEN_W    = 16;
	localparam int unsigned LEN_WIDTH_DEF = 16;

	localparam logic [63:0] MIX_MUL    = 64'hc6a4a7935bd1e995;
	localparam logic [31:0] MIX_MUL_LO = MIX_MUL[31:0];
	localparam logic [31:0] MIX_MUL_HI = MIX_MUL[63:32];
	localparam int unsigned MIX_SHIFT  = 47;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD_LEN,
		OP_LOAD_WORD,
		OP_MUL0,
		OP_MUL1,
		OP_MUL2,
		OP_XSH,
		OP_H_SEED,
		OP_MIX_H,
		OP_TAIL,
		OP_FIN,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t  op;
		logic wr_h;
		logic take;
	} cmd_t;

	typedef struct packed {
		logic accepted;
		logic first;
		logic full;
		logic tail;
		logic last;
		logic out_full;
	} status_t;

	function automatic logic [63:0] byte_mask(input logic [2:0] n);
		logic [63:0] m;
		m = '0;
		for (int i = 0; i < 8; i++) begin
			if (3'(i) < n) begin
				m[i*8 +: 8] = 8'hff;
			end
		end
		return m;
	endfunction

endpackage

/* rtl/mh64a_in_if.sv */
// message word channel: valid/ready plus one word of the message
// depends on mh64a_pkg
interface mh64a_in_if;
	logic                              valid;
	logic                              ready;
	logic [mh64a_pkg::WORD_W-1:0]      data_word;
	logic [mh64a_pkg::COUNT_W-1:0]     byte_count;
	logic                              first_word;
	logic                              last_word;
	logic [mh64a_pkg::MSG_LEN_W-1:0]   message_len;

	modport source(output valid, data_word, byte_count, first_word, last_word, message_len,
		input ready);
	modport sink(input valid, data_word, byte_count, first_word, last_word, message_len,
		output ready);
endinterface

/* rtl/mh64a_out_if.sv */
// hash result channel: valid/ready plus the finished hash
// depends on mh64a_pkg
interface mh64a_out_if;
	logic                         valid;
	logic                         ready;
	logic [mh64a_pkg::WORD_W-1:0] hash_value;

	modport source(output valid, hash_value, input ready);
	modport sink(input valid, hash_value, output ready);
endinterface

/* rtl/murmur_hash_64a.sv */
// MurmurHash64A over a stream of 64-bit little-endian message words, one seed register.
// Takes one message beat at a time on msg and delivers each finished hash on digest;
// built from mh64a_ctrl and mh64a_datapath, types from mh64a_pkg.
// Every 64-bit multiply goes through one shared 32x32 multiplier, which sets the pace: a
// full eight-byte beat sends its word, the mixed word and the hash through it, a beat of
// 1 to 7 bytes only the hash, and an empty beat nothing. A beat marked first also takes
// the length times the mixing constant, then the seed, and a beat marked last adds
// finalization plus any wait for the previous hash to be taken. The finished hash sits in an
// output register, so the next beat may be accepted while it waits.
// The seed is written with cfg_we/cfg_wdata and should only change between messages.
module murmur_hash_64a #(
	parameter int unsigned LEN_WIDTH = mh64a_pkg::LEN_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [mh64a_pkg::WORD_W-1:0] cfg_wdata,
	mh64a_in_if.sink                     msg,
	mh64a_out_if.source                  digest
);

	mh64a_pkg::cmd_t    cmd;
	mh64a_pkg::status_t st;

	mh64a_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd)
	);

	mh64a_datapath #(
		.LEN_WIDTH (LEN_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.msg       (msg),
		.digest    (digest),
		.cmd       (cmd),
		.st        (st)
	);

endmodule

/* rtl/mh64a_datapath.sv */
// hash datapath: item registers, seed, running hash, shared 32x32 multiplier, result register
// depends on mh64a_pkg, mh64a_in_if, mh64a_out_if and the assertion macros
`include "murmur_hash_64a_macros.svh"

module mh64a_datapath #(
	parameter int unsigned LEN_WIDTH = mh64a_pkg::LEN_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mh64a_pkg::WORD_W-1:0]  cfg_wdata,
	mh64a_in_if.sink                      msg,
	mh64a_out_if.source                   digest,
	input  mh64a_pkg::cmd_t               cmd,
	output mh64a_pkg::status_t            st
);

	localparam int unsigned LenBits =
		(LEN_WIDTH < mh64a_pkg::MSG_LEN_W) ? LEN_WIDTH : mh64a_pkg::MSG_LEN_W;

	logic [63:0]         seed_q;
	logic [63:0]         h_q;
	logic [63:0]         x_q;
	logic [63:0]         p_q;
	logic [63:0]         res_q;
	logic                out_valid_q;
	logic [63:0]         word_q;
	logic [3:0]          count_q;
	logic                first_q;
	logic                last_q;
	logic [LenBits-1:0]  len_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;
	logic [31:0] mid_sum;
	logic [63:0] mul_res;
	logic        take;

	assign take = msg.valid && msg.ready;

	// one 32x32 product per cycle, low 64 bits built over three phases
	assign mul_a   = (cmd.op == mh64a_pkg::OP_MUL2) ? x_q[63:32] : x_q[31:0];
	assign mul_b   = (cmd.op == mh64a_pkg::OP_MUL1) ? mh64a_pkg::MIX_MUL_HI
		: mh64a_pkg::MIX_MUL_LO;
	assign prod    = {32'b0, mul_a} * {32'b0, mul_b};
	assign mid_sum = p_q[63:32] + prod[31:0];
	assign mul_res = {mid_sum, p_q[31:0]};

	assign msg.ready         = cmd.take;
	assign digest.valid      = out_valid_q;
	assign digest.hash_value = res_q;

	assign st.accepted = take;
	assign st.first    = first_q;
	assign st.full     = count_q[3];
	assign st.tail     = !count_q[3] && (count_q[2:0] != 3'd0);
	assign st.last     = last_q;
	assign st.out_full = out_valid_q && !digest.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      <= '0;
			h_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				seed_q <= cfg_wdata;
			end
			if (cmd.op == mh64a_pkg::OP_H_SEED) begin
				h_q <= seed_q ^ x_q;
			end else if (cmd.op == mh64a_pkg::OP_MUL2 && cmd.wr_h) begin
				h_q <= mul_res;
			end else if (cmd.op == mh64a_pkg::OP_EMIT) begin
				h_q <= '0;
			end
			if (cmd.op == mh64a_pkg::OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (digest.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			word_q  <= msg.data_word;
			count_q <= msg.byte_count;
			first_q <= msg.first_word;
			last_q  <= msg.last_word;
			len_q   <= msg.message_len[LenBits-1:0];
		end
		unique case (cmd.op)
			mh64a_pkg::OP_LOAD_LEN:  x_q <= 64'(len_q);
			mh64a_pkg::OP_LOAD_WORD: x_q <= word_q;
			mh64a_pkg::OP_MUL0:      p_q <= prod;
			mh64a_pkg::OP_MUL1:      p_q <= mul_res;
			mh64a_pkg::OP_MUL2:      x_q <= mul_res;
			mh64a_pkg::OP_XSH:       x_q <= x_q ^ (x_q >> mh64a_pkg::MIX_SHIFT);
			mh64a_pkg::OP_MIX_H:     x_q <= h_q ^ x_q;
			mh64a_pkg::OP_TAIL:      x_q <= h_q ^ (word_q & mh64a_pkg::byte_mask(count_q[2:0]));
			mh64a_pkg::OP_FIN:       x_q <= h_q ^ (h_q >> mh64a_pkg::MIX_SHIFT);
			mh64a_pkg::OP_EMIT:      res_q <= x_q ^ (x_q >> mh64a_pkg::MIX_SHIFT);
			default: begin
			end
		endcase
	end

	`MH_ASSERT_IMP(a_mul1_order, cmd.op == mh64a_pkg::OP_MUL1, $past(cmd.op) == mh64a_pkg::OP_MUL0)
	`MH_ASSERT_IMP(a_mul2_order, cmd.op == mh64a_pkg::OP_MUL2, $past(cmd.op) == mh64a_pkg::OP_MUL1)
	`MH_ASSERT_NXT(a_emit_result, cmd.op == mh64a_pkg::OP_EMIT, out_valid_q && h_q == '0)

endmodule

/* rtl/mh64a_ctrl.sv */
// hash controller: sequences load, multiply, xor-shift and emit steps for each beat
// depends on mh64a_pkg and the assertion macros
`include "murmur_hash_64a_macros.svh"

module mh64a_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  mh64a_pkg::status_t st,
	output mh64a_pkg::cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DEC,
		S_LEN,
		S_SEED,
		S_WORD,
		S_MUL,
		S_KXSH,
		S_HMIX,
		S_TAIL,
		S_FIN,
		S_EMIT
	} state_t;

	localparam logic [1:0] PH_FIRST = 2'd0;
	localparam logic [1:0] PH_MID   = 2'd1;
	localparam logic [1:0] PH_LAST  = 2'd2;

	state_t     state_q, state_d;
	state_t     ret_q, ret_d;
	state_t     word_next;
	state_t     after_h;
	logic [1:0] phase_q, phase_d;

	// next step once the hash has been started
	always_comb begin
		if (st.full) begin
			word_next = S_WORD;
		end else if (st.tail) begin
			word_next = S_TAIL;
		end else if (st.last) begin
			word_next = S_FIN;
		end else begin
			word_next = S_IDLE;
		end
	end

	assign after_h = st.last ? S_FIN : S_IDLE;

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		phase_d = phase_q;
		unique case (state_q) inside
			S_IDLE: if (st.accepted) begin
				state_d = S_DEC;
			end
			S_DEC:  state_d = st.first ? S_LEN : word_next;
			S_LEN: begin
				state_d = S_MUL;
				ret_d   = S_SEED;
				phase_d = PH_FIRST;
			end
			S_SEED: state_d = word_next;
			S_WORD: begin
				state_d = S_MUL;
				ret_d   = S_KXSH;
				phase_d = PH_FIRST;
			end
			S_KXSH: begin
				state_d = S_MUL;
				ret_d   = S_HMIX;
				phase_d = PH_FIRST;
			end
			S_HMIX, S_TAIL: begin
				state_d = S_MUL;
				ret_d   = after_h;
				phase_d = PH_FIRST;
			end
			S_FIN: begin
				state_d = S_MUL;
				ret_d   = S_EMIT;
				phase_d = PH_FIRST;
			end
			S_MUL: begin
				if (phase_q == PH_LAST) begin
					state_d = ret_q;
				end else begin
					phase_d = phase_q + 2'd1;
				end
			end
			S_EMIT: if (!st.out_full) begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			phase_q <= PH_FIRST;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			phase_q <= phase_d;
		end
	end

	// command decode from the current step
	always_comb begin
		cmd.op   = mh64a_pkg::OP_NONE;
		cmd.wr_h = (ret_q == S_IDLE) || (ret_q == S_FIN);
		cmd.take = (state_q == S_IDLE);
		unique case (state_q)
			S_LEN:  cmd.op = mh64a_pkg::OP_LOAD_LEN;
			S_SEED: cmd.op = mh64a_pkg::OP_H_SEED;
			S_WORD: cmd.op = mh64a_pkg::OP_LOAD_WORD;
			S_KXSH: cmd.op = mh64a_pkg::OP_XSH;
			S_HMIX: cmd.op = mh64a_pkg::OP_MIX_H;
			S_TAIL: cmd.op = mh64a_pkg::OP_TAIL;
			S_FIN:  cmd.op = mh64a_pkg::OP_FIN;
			S_MUL: begin
				if (phase_q == PH_FIRST) begin
					cmd.op = mh64a_pkg::OP_MUL0;
				end else if (phase_q == PH_MID) begin
					cmd.op = mh64a_pkg::OP_MUL1;
				end else begin
					cmd.op = mh64a_pkg::OP_MUL2;
				end
			end
			S_EMIT: if (!st.out_full) begin
				cmd.op = mh64a_pkg::OP_EMIT;
			end
			default: cmd.op = mh64a_pkg::OP_NONE;
		endcase
	end

	`MH_ASSERT_NXT(a_accept_decodes, st.accepted, state_q == S_DEC)
	`MH_ASSERT_IMP(a_emit_has_room, cmd.op == mh64a_pkg::OP_EMIT, !st.out_full)
	`MH_ASSERT_NXT(a_mul_returns, state_q == S_MUL && phase_q == PH_LAST, state_q == $past(ret_q))

endmodule

/* verif/tb.sv */
// testbench for murmur_hash_64a: message words in, 64-bit hashes out, seed register
// keeps its own running hash per accepted beat and checks each digest in order
// depends on mh64a_pkg, mh64a_in_if, mh64a_out_if and the rtl top level

class murmur_tracker;
	bit [63:0] seed_value;
	bit [63:0] partial_hash;
	bit [63:0] pending_hashes[$];
	int        mismatches;

	function new();
		seed_value   = '0;
		partial_hash = '0;
		mismatches   = 0;
	endfunction

	task report(input string what);
		$display("mismatch: %s", what);
		mismatches++;
	endtask

	function void note_word(input bit [63:0] word, input bit [3:0] count, input bit first,
		input bit last, input bit [15:0] msg_len);
		bit [63:0] h;
		bit [63:0] k;
		bit [63:0] keep;
		h = first ? (seed_value ^ (64'(msg_len) * mh64a_pkg::MIX_MUL)) : partial_hash;
		if (count >= 4'd8) begin
			k = word * mh64a_pkg::MIX_MUL;
			k ^= k >> mh64a_pkg::MIX_SHIFT;
			k = k * mh64a_pkg::MIX_MUL;
			h ^= k;
			h = h * mh64a_pkg::MIX_MUL;
		end else if (count != 4'd0) begin
			keep = (64'd1 << (8 * count)) - 64'd1;
			h ^= word & keep;
			h = h * mh64a_pkg::MIX_MUL;
		end
		if (last) begin
			h ^= h >> mh64a_pkg::MIX_SHIFT;
			h = h * mh64a_pkg::MIX_MUL;
			h ^= h >> mh64a_pkg::MIX_SHIFT;
			pending_hashes.push_back(h);
			partial_hash = '0;
		end else begin
			partial_hash = h;
		end
	endfunction

	task check_hash(input logic [63:0] got);
		bit [63:0] want;
		if (pending_hashes.size() == 0) begin
			report($sformatf("hash %h with no message pending", got));
		end else begin
			want = pending_hashes.pop_front();
			if (got !== want) begin
				report($sformatf("hash_value %h, expected %h", got, want));
			end
		end
	endtask
endclass

module tb;
	localparam int DRAIN_CYCLES = 64;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int HOLD_CYCLES  = 400;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [63:0] cfg_wdata;

	mh64a_in_if  msg_bus();
	mh64a_out_if digest_bus();

	murmur_tracker tracker;
	int            send_pct;
	int            stall_pct;
	bit            long_hold;
	int            held_cycles;
	int            words_sent;
	int            cycle_count;

	murmur_hash_64a uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.msg      (msg_bus),
		.digest   (digest_bus)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off
	always @(posedge clk) begin
		if (long_hold && held_cycles < HOLD_CYCLES) begin
			digest_bus.ready <= 1'b0;
			held_cycles++;
		end else begin
			digest_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && msg_bus.valid && msg_bus.ready) begin
			tracker.note_word(msg_bus.data_word, msg_bus.byte_count, msg_bus.first_word,
				msg_bus.last_word, msg_bus.message_len);
		end
		if (arst_n && digest_bus.valid && digest_bus.ready) begin
			tracker.check_hash(digest_bus.hash_value);
		end
	end

	function automatic bit [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	task automatic send_word(input bit [63:0] word, input bit [3:0] count, input bit first,
		input bit last, input bit [15:0] msg_len);
		while ($urandom_range(0, 99) < send_pct) begin
			msg_bus.valid <= 1'b0;
			@(posedge clk);
		end
		msg_bus.valid       <= 1'b1;
		msg_bus.data_word   <= word;
		msg_bus.byte_count  <= count;
		msg_bus.first_word  <= first;
		msg_bus.last_word   <= last;
		msg_bus.message_len <= msg_len;
		@(posedge clk);
		while (!msg_bus.ready) @(posedge clk);
		words_sent++;
	endtask

	task automatic send_message();
		int       kind;
		int       total;
		int       n_words;
		int       left;
		bit [3:0] count;
		bit       last;
		kind = $urandom_range(0, 99);
		if (kind < 75) begin
			if ($urandom_range(0, 9) < 8) total = $urandom_range(0, 40);
			else total = $urandom_range(41, 120);
			n_words = (total + 7) / 8;
			if (n_words == 0) n_words = 1;
			for (int i = 0; i < n_words; i++) begin
				left  = total - 8 * i;
				count = (left >= 8) ? 4'd8 : 4'(left);
				send_word(rand_word(), count, i == 0, i == n_words - 1,
					(i == 0) ? 16'(total) : 16'($urandom));
			end
		end else begin
			// broken sequences: odd counts, stray or missing flags, wrong lengths
			n_words = $urandom_range(1, 4);
			for (int i = 0; i < n_words; i++) begin
				if (i == n_words - 1) last = ($urandom_range(0, 4) != 0);
				else last = ($urandom_range(0, 5) == 0);
				send_word(rand_word(), 4'($urandom_range(0, 15)), $urandom_range(0, 2) == 0,
					last, 16'($urandom));
			end
		end
	endtask

	task automatic load_seed(input bit [63:0] value);
		msg_bus.valid <= 1'b0;
		while (tracker.pending_hashes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.seed_value = value;
	endtask

	initial begin
		int target;
		tracker     = new();
		send_pct    = 0;
		stall_pct   = 0;
		long_hold   = 1'b0;
		held_cycles = 0;
		words_sent  = 0;
		cycle_count = 0;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		msg_bus.valid       = 1'b0;
		msg_bus.data_word   = '0;
		msg_bus.byte_count  = '0;
		msg_bus.first_word  = 1'b0;
		msg_bus.last_word   = 1'b0;
		msg_bus.message_len = '0;
		digest_bus.ready    = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty message, then one full word of all ones
		send_word('1, 4'd0, 1'b1, 1'b1, 16'd0);
		send_word('1, 4'd8, 1'b1, 1'b1, 16'd8);
		// longest length, counts above eight, empty beat mid-message, garbage above tail
		send_word('0, 4'd8, 1'b1, 1'b0, 16'hffff);
		send_word(rand_word(), 4'd15, 1'b0, 1'b0, 16'hffff);
		send_word(rand_word(), 4'd9, 1'b0, 1'b0, 16'd0);
		send_word(rand_word(), 4'd0, 1'b0, 1'b0, 16'd0);
		send_word('1, 4'd5, 1'b0, 1'b1, 16'd0);
		// every tail size
		for (int n = 1; n < 8; n++) begin
			send_word('1, 4'(n), 1'b1, 1'b1, 16'(n));
		end
		// short beat that is not last
		send_word(rand_word(), 4'd3, 1'b1, 1'b0, 16'd11);
		send_word(rand_word(), 4'd8, 1'b0, 1'b1, 16'd11);
		// no first beat after a digest, continues from cleared state
		send_word(rand_word(), 4'd8, 1'b0, 1'b1, 16'd8);
		send_word(rand_word(), 4'd8, 1'b1, 1'b0, 16'd16);
		send_word(rand_word(), 4'd8, 1'b0, 1'b1, 16'd16);
		// first beat in the middle restarts the hash
		send_word(rand_word(), 4'd8, 1'b1, 1'b0, 16'd16);
		send_word(rand_word(), 4'd8, 1'b1, 1'b1, 16'd8);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					load_seed('1);
					send_pct = 0;
					stall_pct <= 0;
				end
				1: begin
					load_seed(rand_word());
					send_pct = 77;
					stall_pct <= 0;
				end
				2: begin
					load_seed('0);
					send_pct = 0;
					stall_pct <= 77;
				end
				default: begin
					load_seed({1'b1, 63'(rand_word())});
					send_pct = 35;
					stall_pct <= 35;
				end
			endcase
			target = words_sent + 150;
			while (words_sent < target) send_message();
		end

		// hold the digest side off while full single-beat messages keep coming
		load_seed(64'd1);
		send_pct = 0;
		stall_pct <= 0;
		long_hold <= 1'b1;
		for (int i = 0; i < 40; i++) begin
			send_word(rand_word(), 4'd8, 1'b1, 1'b1, 16'd8);
		end

		msg_bus.valid <= 1'b0;
		while (tracker.pending_hashes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule

/* murmur_hash_64a.f */
+incdir+rtl
rtl/mh64a_pkg.sv
rtl/mh64a_in_if.sv
rtl/mh64a_out_if.sv
rtl/mh64a_datapath.sv
rtl/mh64a_ctrl.sv
rtl/murmur_hash_64a.sv
verif/tb.sv
